// File: hw/rtl/dhe_pkg.sv
package dhe_pkg;

   // widths fixed by the field definitions
   localparam int ACTION_WIDTH    = 2;
   localparam int BYTE_WIDTH      = 8;
   localparam int OUTCOME_WIDTH   = 2;
   localparam int TIMEOUT_WIDTH   = 16;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int PROGRESS_WIDTH  = 4;

   // defaults for the top level parameters
   localparam int DEF_WINDOW_BYTES    = 39;
   localparam int DEF_CLIENT_ATTEMPTS = 4;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // handshake text lengths
   localparam logic [PROGRESS_WIDTH-1:0] SHORT_LEN = 4'd6;
   localparam logic [PROGRESS_WIDTH-1:0] LONG_LEN  = 4'd12;
   localparam logic [BYTE_WIDTH-1:0]     TILDE     = 8'h7e;

   // action codes
   localparam logic [ACTION_WIDTH-1:0] ACT_START = 2'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_BYTE  = 2'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_CLOSE = 2'd2;
   localparam logic [ACTION_WIDTH-1:0] ACT_TICK  = 2'd3;

   // outcome codes
   localparam logic [OUTCOME_WIDTH-1:0] OUT_PENDING   = 2'd0;
   localparam logic [OUTCOME_WIDTH-1:0] OUT_CONNECTED = 2'd1;
   localparam logic [OUTCOME_WIDTH-1:0] OUT_FAILURE   = 2'd2;
   localparam logic [OUTCOME_WIDTH-1:0] OUT_TIMEOUT   = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SERVER_ROLE = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIMEOUT     = 1'b1;

   // what the back has to emit for one accepted item
   typedef enum logic [1:0] {
      CMD_SINGLE = 2'd0,
      CMD_SHORT  = 2'd1,
      CMD_LONG   = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type               kind;
      logic [OUTCOME_WIDTH-1:0]   outcome;
   } cmd_type;

   // handshake text, client greeting followed by the server reply
   function automatic logic [BYTE_WIDTH-1:0] hs_char(input logic [PROGRESS_WIDTH-1:0] idx);
      logic [BYTE_WIDTH-1:0] c;
      case (idx)
         4'd0:    c = 8'h43; // C
         4'd1:    c = 8'h4c; // L
         4'd2:    c = 8'h49; // I
         4'd3:    c = 8'h45; // E
         4'd4:    c = 8'h4e; // N
         4'd5:    c = 8'h54; // T
         4'd6:    c = 8'h53; // S
         4'd7:    c = 8'h45; // E
         4'd8:    c = 8'h52; // R
         4'd9:    c = 8'h56; // V
         4'd10:   c = 8'h45; // E
         4'd11:   c = 8'h52; // R
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// File: hw/rtl/dhe_front.sv
module dhe_front #(
   parameter int WINDOW_BYTES    = dhe_pkg::DEF_WINDOW_BYTES,
   parameter int CLIENT_ATTEMPTS = dhe_pkg::DEF_CLIENT_ATTEMPTS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic [dhe_pkg::ACTION_WIDTH-1:0]      action,
   input  logic [dhe_pkg::BYTE_WIDTH-1:0]        rx_byte,
   input  logic                                  csr_write,
   input  logic [dhe_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [dhe_pkg::CSR_DATA_WIDTH-1:0]    csr_data,
   output dhe_pkg::cmd_type                      cmd
);
   import dhe_pkg::*;

   localparam int BR_WIDTH   = $clog2(WINDOW_BYTES + 1);
   localparam int ATT_WIDTH  = $clog2(CLIENT_ATTEMPTS + 1);
   localparam int QUOT_SHIFT = TIMEOUT_WIDTH + $clog2(CLIENT_ATTEMPTS);
   localparam int QUOT_MULT  = ((1 << QUOT_SHIFT) + CLIENT_ATTEMPTS - 1) / CLIENT_ATTEMPTS;
   localparam int PROD_WIDTH = TIMEOUT_WIDTH + QUOT_SHIFT + 1;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'b01,
      PHASE_WAIT = 2'b10
   } phase_type;

   logic                        server_ff;
   logic [TIMEOUT_WIDTH-1:0]    timeout_ff;
   logic [TIMEOUT_WIDTH-1:0]    quot_ff;
   logic [PROD_WIDTH-1:0]       prod;

   phase_type                   phase_ff, phase_in;
   logic [BR_WIDTH-1:0]         br_ff, br_in;
   logic [PROGRESS_WIDTH-1:0]   mp_ff, mp_in;
   logic                        tilde_ff, tilde_in;
   logic                        zero_ff, zero_in;
   logic [ATT_WIDTH-1:0]        att_ff, att_in;
   logic [TIMEOUT_WIDTH-1:0]    ticks_ff, ticks_in;

   logic [PROGRESS_WIDTH-1:0]   plen;
   logic [BR_WIDTH-1:0]         br_inc;
   logic [PROGRESS_WIDTH-1:0]   mp_byte;
   logic                        tilde_byte;
   logic                        zero_byte;
   logic [TIMEOUT_WIDTH-1:0]    ticks_dec;
   logic [TIMEOUT_WIDTH-1:0]    arm_ticks;

   // per-attempt time by reciprocal multiply, worked out on each timeout write
   assign prod = PROD_WIDTH'(csr_data) * PROD_WIDTH'(QUOT_MULT);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         server_ff  <= 1'b0;
         timeout_ff <= '0;
         quot_ff    <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SERVER_ROLE: server_ff <= csr_data[0];
            CSR_TIMEOUT: begin
               timeout_ff <= csr_data;
               quot_ff    <= prod[QUOT_SHIFT +: TIMEOUT_WIDTH];
            end
            default: ;
         endcase
      end
   end

   assign plen      = server_ff ? SHORT_LEN : LONG_LEN;
   assign arm_ticks = server_ff ? timeout_ff : quot_ff;
   assign ticks_dec = ticks_ff - 1'b1;
   assign br_inc    = (br_ff < BR_WIDTH'(WINDOW_BYTES)) ? br_ff + 1'b1 : br_ff;

   // window update for a received byte
   always_comb begin
      mp_byte    = mp_ff;
      tilde_byte = tilde_ff;
      zero_byte  = zero_ff;
      if (!zero_ff) begin
         if (rx_byte == '0) begin
            zero_byte = 1'b1;
         end else begin
            if (rx_byte == TILDE) begin
               tilde_byte = 1'b1;
            end
            if (mp_ff < plen && rx_byte == hs_char(mp_ff)) begin
               mp_byte = mp_ff + 1'b1;
            end else begin
               mp_byte = (rx_byte == hs_char('0)) ? 4'd1 : 4'd0;
            end
         end
      end
   end

   // classify the word and work out the next handshake state
   always_comb begin
      phase_in    = phase_ff;
      br_in       = br_ff;
      mp_in       = mp_ff;
      tilde_in    = tilde_ff;
      zero_in     = zero_ff;
      att_in      = att_ff;
      ticks_in    = ticks_ff;
      cmd.kind    = CMD_SINGLE;
      cmd.outcome = OUT_PENDING;
      if (action == ACT_START) begin
         att_in   = server_ff ? ATT_WIDTH'(1) : ATT_WIDTH'(CLIENT_ATTEMPTS);
         br_in    = '0;
         mp_in    = '0;
         tilde_in = 1'b0;
         zero_in  = 1'b0;
         ticks_in = arm_ticks;
         phase_in = PHASE_WAIT;
         cmd.kind = server_ff ? CMD_SINGLE : CMD_SHORT;
      end else if (phase_ff == PHASE_WAIT) begin
         unique case (action)
            ACT_BYTE: begin
               br_in    = br_inc;
               mp_in    = mp_byte;
               tilde_in = tilde_byte;
               zero_in  = zero_byte;
               if (mp_byte >= plen) begin
                  phase_in    = PHASE_IDLE;
                  cmd.kind    = server_ff ? CMD_LONG : CMD_SINGLE;
                  cmd.outcome = OUT_CONNECTED;
               end else if (tilde_byte && br_inc >= BR_WIDTH'(plen)) begin
                  phase_in    = PHASE_IDLE;
                  cmd.outcome = OUT_CONNECTED;
               end else if (br_inc >= BR_WIDTH'(WINDOW_BYTES)) begin
                  phase_in    = PHASE_IDLE;
                  cmd.outcome = OUT_FAILURE;
               end
            end
            ACT_CLOSE: begin
               phase_in    = PHASE_IDLE;
               cmd.outcome = OUT_FAILURE;
            end
            ACT_TICK: begin
               if (ticks_ff != '0) begin
                  ticks_in = ticks_dec;
                  if (ticks_dec == '0) begin
                     if (!server_ff && att_ff > ATT_WIDTH'(1)) begin
                        // retry: fresh window and greeting again
                        att_in   = att_ff - 1'b1;
                        br_in    = '0;
                        mp_in    = '0;
                        tilde_in = 1'b0;
                        zero_in  = 1'b0;
                        ticks_in = arm_ticks;
                        cmd.kind = CMD_SHORT;
                     end else begin
                        if (att_ff != '0) begin
                           att_in = att_ff - 1'b1;
                        end
                        phase_in    = PHASE_IDLE;
                        cmd.outcome = OUT_TIMEOUT;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // handshake state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         br_ff    <= '0;
         mp_ff    <= '0;
         tilde_ff <= 1'b0;
         zero_ff  <= 1'b0;
         att_ff   <= '0;
         ticks_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         br_ff    <= br_in;
         mp_ff    <= mp_in;
         tilde_ff <= tilde_in;
         zero_ff  <= zero_in;
         att_ff   <= att_in;
         ticks_ff <= ticks_in;
      end
   end

endmodule

// File: hw/rtl/dhe_cmd_queue.sv
module dhe_cmd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dhe_pkg::cmd_type   push_cmd,
   input  logic               pop,
   output dhe_pkg::cmd_type   head_cmd,
   output logic               full,
   output logic               empty
);
   import dhe_pkg::*;

   localparam int PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_WIDTH-1:0]   count_ff;
   logic                   do_push, do_pop;

   assign full     = (count_ff == CNT_WIDTH'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = entry_ff[rd_ptr_ff];

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// File: hw/rtl/dhe_back.sv
module dhe_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dhe_pkg::cmd_type                     head_cmd,
   input  logic                                 head_empty,
   input  logic                                 rsp_pop,
   output logic                                 head_pop,
   output logic                                 rsp_tx_valid,
   output logic [dhe_pkg::BYTE_WIDTH-1:0]       rsp_tx_byte,
   output logic [dhe_pkg::OUTCOME_WIDTH-1:0]    rsp_outcome,
   output logic                                 rsp_last
);
   import dhe_pkg::*;

   logic [PROGRESS_WIDTH-1:0] idx_ff, idx_in;
   logic [PROGRESS_WIDTH-1:0] len;
   logic                      final_word;
   logic                      take;

   // number of words the command expands to
   always_comb begin
      case (head_cmd.kind)
         CMD_SHORT: len = SHORT_LEN;
         CMD_LONG:  len = LONG_LEN;
         default:   len = 4'd1;
      endcase
   end

   assign final_word = (idx_ff == len - 1'b1);
   assign take       = rsp_pop && !head_empty;
   assign head_pop   = take && final_word;
   assign idx_in     = final_word ? '0 : idx_ff + 1'b1;

   // result word for the current position
   always_comb begin
      rsp_tx_valid = (head_cmd.kind == CMD_SHORT) || (head_cmd.kind == CMD_LONG);
      rsp_tx_byte  = rsp_tx_valid ? hs_char(idx_ff) : '0;
      rsp_last     = final_word;
      if (!rsp_tx_valid) begin
         rsp_outcome = head_cmd.outcome;
      end else if (final_word && head_cmd.kind == CMD_LONG) begin
         rsp_outcome = OUT_CONNECTED;
      end else begin
         rsp_outcome = OUT_PENDING;
      end
   end

   // position within the command
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (take) begin
         idx_ff <= idx_in;
      end
   end

endmodule

// File: hw/rtl/dialup_handshake_engine.sv
// Dial-up link handshake engine. Words pushed on req_ are start, received byte, link
// closed and one-second tick events; results come out of the rsp_ queue as transmit
// bytes and an outcome on the word flagged last. Every accepted word yields at least
// one result: a client start and every client retry yield the six greeting bytes, a
// server greeting match yields the twelve reply bytes, all other words yield a single
// result. The front classifies one word per cycle and updates the handshake state; a
// four-entry command queue decouples it from the back, which emits one result word per
// cycle while rsp_pop is high. Sustained rate is one word per cycle while each word
// yields one result; a word yielding n results holds the back for n pops, and req_full
// rises once the queue holds four commands. csr_ready is always high; a timeout write
// also stores the per-attempt client time, worked out by reciprocal multiply in the
// same cycle, and both take effect from the next cycle. No clearing pass after reset.
module dialup_handshake_engine #(
   parameter int WINDOW_BYTES    = dhe_pkg::DEF_WINDOW_BYTES,
   parameter int CLIENT_ATTEMPTS = dhe_pkg::DEF_CLIENT_ATTEMPTS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [dhe_pkg::ACTION_WIDTH-1:0]     req_action,
   input  logic [dhe_pkg::BYTE_WIDTH-1:0]       req_rx_byte,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic                                 rsp_tx_valid,
   output logic [dhe_pkg::BYTE_WIDTH-1:0]       rsp_tx_byte,
   output logic [dhe_pkg::OUTCOME_WIDTH-1:0]    rsp_outcome,
   output logic                                 rsp_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dhe_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [dhe_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import dhe_pkg::*;

   cmd_type front_cmd;
   cmd_type head_cmd;
   logic    accept;
   logic    q_full;
   logic    q_empty;
   logic    head_pop;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !q_full;
   assign req_full  = q_full;
   assign rsp_empty = q_empty;

   // front: handshake state and classification
   dhe_front #(
      .WINDOW_BYTES    (WINDOW_BYTES),
      .CLIENT_ATTEMPTS (CLIENT_ATTEMPTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .action    (req_action),
      .rx_byte   (req_rx_byte),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (front_cmd)
   );

   // command queue between front and back
   dhe_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_cmd (front_cmd),
      .pop      (head_pop),
      .head_cmd (head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   // back: expand commands into result words
   dhe_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_cmd     (head_cmd),
      .head_empty   (q_empty),
      .rsp_pop      (rsp_pop),
      .head_pop     (head_pop),
      .rsp_tx_valid (rsp_tx_valid),
      .rsp_tx_byte  (rsp_tx_byte),
      .rsp_outcome  (rsp_outcome),
      .rsp_last     (rsp_last)
   );

   // checks
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_outcome_on_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_last) |-> (rsp_outcome == OUT_PENDING))
      else $error("outcome set on a word that is not last");

   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_tx_valid) |-> rsp_last)
      else $error("result without transmit byte is not last");

   a_pop_holds_queue: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_last && rsp_pop) |=> !rsp_empty)
      else $error("queue drained in the middle of a byte burst");

endmodule

// File: test/dialup_handshake_engine_tb.sv
module dialup_handshake_engine_tb;
   import dhe_pkg::*;

   localparam int WINDOW          = DEF_WINDOW_BYTES;
   localparam int CLIENT_TRIES    = DEF_CLIENT_ATTEMPTS;
   localparam int DRAIN_CYCLES    = 4;
   localparam int WATCHDOG_LIMIT  = 400;
   localparam int RANDOM_WORDS    = 250;
   localparam int SESSION_WORDS   = 60;
   localparam logic [8*12-1:0] HS_TEXT = "CLIENTSERVER";

   typedef enum logic {LINK_IDLE, LINK_WAIT} link_state_type;
   typedef enum int {
      SES_MATCH, SES_TILDE, SES_ZERO, SES_WILD, SES_EXPIRE, SES_CLOSE, SES_RESTART
   } session_kind_type;

   typedef struct packed {
      logic                     tx_valid;
      logic [BYTE_WIDTH-1:0]    tx_byte;
      logic [OUTCOME_WIDTH-1:0] outcome;
      logic                     last;
   } result_word_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_push = 1'b0;
   logic                       req_full;
   logic [ACTION_WIDTH-1:0]    req_action = ACT_START;
   logic [BYTE_WIDTH-1:0]      req_rx_byte = 8'h00;
   logic                       rsp_empty;
   logic                       rsp_pop = 1'b0;
   logic                       rsp_tx_valid;
   logic [BYTE_WIDTH-1:0]      rsp_tx_byte;
   logic [OUTCOME_WIDTH-1:0]   rsp_outcome;
   logic                       rsp_last;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_SERVER_ROLE;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;

   // handshake mirror: registers and link state
   bit                       cfg_server = 1'b0;
   logic [TIMEOUT_WIDTH-1:0] cfg_timeout = '0;
   link_state_type           link_state = LINK_IDLE;
   int unsigned              rx_count = 0;
   int unsigned              match_len = 0;
   int unsigned              attempts = 0;
   int unsigned              ticks = 0;
   bit                       tilde_hit = 1'b0;
   bit                       zero_hit = 1'b0;

   result_word_type awaited_words[$];

   // run statistics
   int unsigned live_words = 0;
   int unsigned ignored_words = 0;
   int unsigned results_seen = 0;
   int unsigned reg_writes = 0;
   int unsigned connects = 0;
   int unsigned failures = 0;
   int unsigned expiries = 0;
   int unsigned retries = 0;
   int unsigned errors = 0;
   int unsigned quiet_cycles = 0;
   int          pop_hold = 0;
   bit          idling_on = 1'b1;

   dialup_handshake_engine u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_action   (req_action),
      .req_rx_byte  (req_rx_byte),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_tx_valid (rsp_tx_valid),
      .rsp_tx_byte  (rsp_tx_byte),
      .rsp_outcome  (rsp_outcome),
      .rsp_last     (rsp_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [BYTE_WIDTH-1:0] text_char(input int unsigned i);
      return HS_TEXT[8*(11-i) +: 8];
   endfunction

   function automatic void await_word(input logic valid, input logic [BYTE_WIDTH-1:0] b,
                                      input logic [OUTCOME_WIDTH-1:0] oc, input logic fin);
      result_word_type w;
      w.tx_valid = valid;
      w.tx_byte  = b;
      w.outcome  = oc;
      w.last     = fin;
      awaited_words.push_back(w);
   endfunction

   // a run of handshake text, outcome on the closing word only
   function automatic void await_text(input int unsigned len,
                                      input logic [OUTCOME_WIDTH-1:0] fin_outcome);
      for (int unsigned i = 0; i < len; i++) begin
         if (i + 1 == len) await_word(1'b1, text_char(i), fin_outcome, 1'b1);
         else await_word(1'b1, text_char(i), OUT_PENDING, 1'b0);
      end
   endfunction

   function automatic void arm_attempt();
      rx_count   = 0;
      match_len  = 0;
      tilde_hit  = 1'b0;
      zero_hit   = 1'b0;
      ticks      = cfg_server ? cfg_timeout : cfg_timeout / CLIENT_TRIES;
      link_state = LINK_WAIT;
   endfunction

   // predict the result words of one accepted event word
   function automatic void advance_handshake(input logic [ACTION_WIDTH-1:0] act,
                                             input logic [BYTE_WIDTH-1:0] b);
      int unsigned plen;
      bit          expired;
      plen = cfg_server ? SHORT_LEN : LONG_LEN;
      if (act == ACT_START) begin
         live_words++;
         attempts = cfg_server ? 1 : CLIENT_TRIES;
         arm_attempt();
         if (cfg_server) await_word(1'b0, 8'h00, OUT_PENDING, 1'b1);
         else await_text(SHORT_LEN, OUT_PENDING);
      end else if (link_state != LINK_WAIT) begin
         ignored_words++;
         await_word(1'b0, 8'h00, OUT_PENDING, 1'b1);
      end else if (act == ACT_BYTE) begin
         live_words++;
         if (rx_count < WINDOW) rx_count++;
         // search stops for good at the first zero byte
         if (!zero_hit) begin
            if (b == 8'h00) begin
               zero_hit = 1'b1;
            end else begin
               if (b == TILDE) tilde_hit = 1'b1;
               if (match_len < plen && b == text_char(match_len)) match_len++;
               else match_len = (b == text_char(0)) ? 1 : 0;
            end
         end
         if (match_len >= plen) begin
            link_state = LINK_IDLE;
            connects++;
            if (cfg_server) await_text(LONG_LEN, OUT_CONNECTED);
            else await_word(1'b0, 8'h00, OUT_CONNECTED, 1'b1);
         end else if (tilde_hit && rx_count >= plen) begin
            link_state = LINK_IDLE;
            connects++;
            await_word(1'b0, 8'h00, OUT_CONNECTED, 1'b1);
         end else if (rx_count >= WINDOW) begin
            link_state = LINK_IDLE;
            failures++;
            await_word(1'b0, 8'h00, OUT_FAILURE, 1'b1);
         end else begin
            await_word(1'b0, 8'h00, OUT_PENDING, 1'b1);
         end
      end else if (act == ACT_CLOSE) begin
         live_words++;
         link_state = LINK_IDLE;
         failures++;
         await_word(1'b0, 8'h00, OUT_FAILURE, 1'b1);
      end else begin
         // one-second tick
         live_words++;
         expired = 1'b0;
         if (ticks != 0) begin
            ticks--;
            expired = (ticks == 0);
         end
         if (!expired) begin
            await_word(1'b0, 8'h00, OUT_PENDING, 1'b1);
         end else if (!cfg_server && attempts > 1) begin
            attempts--;
            retries++;
            arm_attempt();
            await_text(SHORT_LEN, OUT_PENDING);
         end else begin
            if (attempts > 0) attempts--;
            link_state = LINK_IDLE;
            expiries++;
            await_word(1'b0, 8'h00, OUT_TIMEOUT, 1'b1);
         end
      end
   endfunction

   function automatic void apply_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                          input logic [CSR_DATA_WIDTH-1:0] value);
      reg_writes++;
      if (idx == CSR_SERVER_ROLE) cfg_server = value[0];
      else if (idx == CSR_TIMEOUT) cfg_timeout = value[TIMEOUT_WIDTH-1:0];
   endfunction

   // compare one popped result word with the oldest prediction
   function automatic void check_result();
      result_word_type want;
      results_seen++;
      if (awaited_words.size() == 0) begin
         $error("result word with none awaited: tx_valid %0d tx_byte %02h %s %0d last %0d",
                rsp_tx_valid, rsp_tx_byte, "outcome", rsp_outcome, rsp_last);
         errors++;
         return;
      end
      want = awaited_words.pop_front();
      if (rsp_tx_valid !== want.tx_valid) begin
         $error("tx_valid: expected %0d, got %0d", want.tx_valid, rsp_tx_valid);
         errors++;
      end
      if (rsp_tx_byte !== want.tx_byte) begin
         $error("tx_byte: expected %02h, got %02h", want.tx_byte, rsp_tx_byte);
         errors++;
      end
      if (rsp_outcome !== want.outcome) begin
         $error("outcome: expected %0d, got %0d", want.outcome, rsp_outcome);
         errors++;
      end
      if (rsp_last !== want.last) begin
         $error("last: expected %0d, got %0d", want.last, rsp_last);
         errors++;
      end
   endfunction

   // monitor: register writes, then event words, then result words
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) apply_register(csr_index, csr_data);
         if (req_push && !req_full) advance_handshake(req_action, req_rx_byte);
         if (rsp_pop && !rsp_empty) check_result();
         if ((csr_valid && csr_ready) || (req_push && !req_full) || (rsp_pop && !rsp_empty))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side, random stall bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (pop_hold > 0) begin
         pop_hold = pop_hold - 1;
         rsp_pop <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         pop_hold = $urandom_range(1, 19) - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // stimulus tasks start and return just after a falling edge
   task automatic send_word(input logic [ACTION_WIDTH-1:0] act,
                            input logic [BYTE_WIDTH-1:0] b);
      if (idling_on && $urandom_range(0, 7) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_push    <= 1'b1;
      req_action  <= act;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      do @(negedge clock); while (awaited_words.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_greeting(input int unsigned from, input int unsigned upto);
      for (int unsigned i = from; i < upto; i++) send_word(ACT_BYTE, text_char(i));
   endtask

   function automatic logic [BYTE_WIDTH-1:0] noise_byte();
      return 8'($urandom_range(1, 125));
   endfunction

   // byte, close and tick with no handshake running
   task automatic test_idle_events();
      send_word(ACT_BYTE, 8'hFF);
      send_word(ACT_CLOSE, 8'h00);
      send_word(ACT_TICK, 8'hAA);
   endtask

   task automatic test_server_reply();
      write_reg(CSR_SERVER_ROLE, 16'd1);
      write_reg(CSR_TIMEOUT, 16'hFFFF);
      send_word(ACT_START, 8'hFF);
      send_greeting(0, SHORT_LEN);
   endtask

   // tilde once enough bytes are in: connected, no reply
   task automatic test_tilde_shortcut();
      send_word(ACT_START, 8'h00);
      send_word(ACT_BYTE, TILDE);
      repeat (4) send_word(ACT_BYTE, 8'h80);
      send_word(ACT_BYTE, 8'h7F);
   endtask

   task automatic test_timeouts();
      // server: single timeout
      write_reg(CSR_TIMEOUT, 16'd1);
      send_word(ACT_START, 8'h55);
      send_word(ACT_TICK, 8'h00);
      // client: one tick per attempt, three retries then timeout
      write_reg(CSR_SERVER_ROLE, 16'd0);
      write_reg(CSR_TIMEOUT, 16'd4);
      send_word(ACT_START, 8'h00);
      repeat (4) send_word(ACT_TICK, 8'hFF);
   endtask

   // per-attempt time of zero never expires; restart then link closed
   task automatic test_restart_and_close();
      write_reg(CSR_TIMEOUT, 16'd3);
      send_word(ACT_START, 8'h00);
      send_word(ACT_TICK, 8'h00);
      send_word(ACT_START, 8'h00);
      send_word(ACT_CLOSE, 8'hFF);
   endtask

   // client three bytes into the pattern, then switched to server
   task automatic test_role_switch();
      write_reg(CSR_TIMEOUT, 16'd0);
      send_word(ACT_START, 8'h00);
      send_greeting(0, 3);
      write_reg(CSR_SERVER_ROLE, 16'd1);
      send_greeting(3, SHORT_LEN);
   endtask

   // zero byte hides the rest, window fills up
   task automatic test_window_overflow();
      write_reg(CSR_SERVER_ROLE, 16'd0);
      send_word(ACT_START, 8'h00);
      send_word(ACT_BYTE, text_char(0));
      send_word(ACT_BYTE, 8'h00);
      for (int unsigned i = 2; i < WINDOW; i++)
         send_word(ACT_BYTE, (i == 9) ? TILDE : text_char(i % LONG_LEN));
   endtask

   task automatic run_session();
      session_kind_type        kind;
      int unsigned             r;
      int unsigned             pos;
      int unsigned             plen;
      bit                      tick_now;
      logic [ACTION_WIDTH-1:0] act;
      logic [BYTE_WIDTH-1:0]   b;
      r = $urandom_range(0, 11);
      if (r <= 4) kind = SES_MATCH;
      else if (r == 5) kind = SES_TILDE;
      else if (r == 6) kind = SES_ZERO;
      else if (r == 7) kind = SES_WILD;
      else if (r <= 9) kind = SES_EXPIRE;
      else if (r == 10) kind = SES_CLOSE;
      else kind = SES_RESTART;
      send_word(ACT_START, 8'($urandom));
      pos = 0;
      for (int unsigned k = 0; k < SESSION_WORDS && link_state == LINK_WAIT; k++) begin
         plen = cfg_server ? SHORT_LEN : LONG_LEN;
         act  = ACT_BYTE;
         b    = noise_byte();
         if (kind == SES_EXPIRE) tick_now = ($urandom_range(0, 3) != 0);
         else tick_now = ($urandom_range(0, 15) == 0);
         if (tick_now) begin
            act = ACT_TICK;
            b   = 8'($urandom);
         end else begin
            case (kind)
               SES_MATCH: begin
                  if ($urandom_range(0, 9) == 0) begin
                     pos = 0;
                  end else begin
                     b   = text_char(pos % plen);
                     pos = (pos + 1) % plen;
                  end
               end
               SES_TILDE:   if ($urandom_range(0, 3) == 0) b = TILDE;
               SES_ZERO:    b = (k == 2) ? 8'h00 : text_char(k % LONG_LEN);
               SES_WILD:    b = 8'($urandom);
               SES_CLOSE:   if (k == 3) act = ACT_CLOSE;
               SES_RESTART: if (k == 3) act = ACT_START;
               default: ;
            endcase
         end
         send_word(act, b);
      end
   endtask

   // random settings, mostly well-formed sessions, some stray words
   task automatic test_random_sessions();
      int unsigned              goal;
      logic [TIMEOUT_WIDTH-1:0] t;
      goal = live_words + RANDOM_WORDS;
      while (live_words < goal) begin
         if (live_words + RANDOM_WORDS / 8 >= goal) idling_on = 1'b0;
         else idling_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 5))
            0:       t = '0;
            1:       t = '1;
            2:       t = TIMEOUT_WIDTH'($urandom_range(1, 3));
            5:       t = TIMEOUT_WIDTH'($urandom);
            default: t = TIMEOUT_WIDTH'($urandom_range(4, 24));
         endcase
         write_reg(CSR_SERVER_ROLE, CSR_DATA_WIDTH'($urandom_range(0, 1)));
         write_reg(CSR_TIMEOUT, t);
         repeat (3) begin
            run_session();
            if ($urandom_range(0, 4) == 0)
               send_word(ACTION_WIDTH'($urandom_range(1, 3)), 8'($urandom));
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_idle_events();
      test_server_reply();
      test_tilde_shortcut();
      test_timeouts();
      test_restart_and_close();
      test_role_switch();
      test_window_overflow();
      test_random_sessions();
      wait_idle();
      $display("covered %0d event words (%0d more ignored while idle),",
               live_words, ignored_words);
      $display("   %0d result words, %0d register writes", results_seen, reg_writes);
      $display("handshakes: %0d connected, %0d failed, %0d timed out, %0d client retries",
               connects, failures, expiries, retries);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/dhe_pkg.sv
hw/rtl/dhe_front.sv
hw/rtl/dhe_cmd_queue.sv
hw/rtl/dhe_back.sv
hw/rtl/dialup_handshake_engine.sv
test/dialup_handshake_engine_tb.sv
